>>> src/lts_pkg.sv
`default_nettype none
package lts_pkg;

	localparam int MAX_TEXT_LEN   = 255;
	localparam int MAX_NUMBER_LEN = 63;
	localparam int POS_BITS       = 20;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

	localparam logic [POS_BITS-1:0] LINE_MAX = '1;

	localparam logic [5:0] K_IDENT  = 6'd16;
	localparam logic [5:0] K_NUMBER = 6'd17;
	localparam logic [5:0] K_STRING = 6'd18;
	localparam logic [5:0] K_LPAREN = 6'd19;
	localparam logic [5:0] K_RPAREN = 6'd20;
	localparam logic [5:0] K_LBRACE = 6'd21;
	localparam logic [5:0] K_RBRACE = 6'd22;
	localparam logic [5:0] K_COMMA  = 6'd23;
	localparam logic [5:0] K_DOT    = 6'd24;
	localparam logic [5:0] K_SEMI   = 6'd25;
	localparam logic [5:0] K_PLUS   = 6'd26;
	localparam logic [5:0] K_MINUS  = 6'd27;
	localparam logic [5:0] K_STAR   = 6'd28;
	localparam logic [5:0] K_SLASH  = 6'd29;
	localparam logic [5:0] K_BANG   = 6'd30;
	localparam logic [5:0] K_EQUAL  = 6'd32;
	localparam logic [5:0] K_GREATER = 6'd34;
	localparam logic [5:0] K_LESS   = 6'd36;
	localparam logic [5:0] K_END    = 6'd38;
	localparam logic [5:0] K_NONE   = 6'd0;

	localparam logic [2:0] E_NONE      = 3'd0;
	localparam logic [2:0] E_BAD_CHAR  = 3'd1;
	localparam logic [2:0] E_UNTERM    = 3'd2;
	localparam logic [2:0] E_NUM_LONG  = 3'd3;
	localparam logic [2:0] E_ID_LONG   = 3'd4;
	localparam logic [2:0] E_STR_LONG  = 3'd5;

	typedef enum logic [3:0] {
		M_IDLE, M_SLASH, M_COMMENT, M_INT, M_DOT, M_FRAC, M_IDENT, M_STRING, M_OP
	} mode_t;

	typedef struct packed {
		logic [5:0]          kind;
		logic [2:0]          err;
		logic [POS_BITS-1:0] start;
		logic [7:0]          len;
		logic [POS_BITS-1:0] line;
	} res_t;

	typedef struct packed {
		res_t [2:0] r;
		logic [1:0] cnt;
	} grp_t;

	// keywords packed big-endian into the low bytes, with their lengths
	localparam logic [47:0] KW_TEXT [16] = '{
		48'h0000_0061_6e64, 48'h0063_6c61_7373, 48'h0000_656c_7365, 48'h0066_616c_7365,
		48'h0000_0066_6f72, 48'h0000_0066_756e, 48'h0000_0000_6966, 48'h0000_006e_696c,
		48'h0000_0000_6f72, 48'h0070_7269_6e74, 48'h7265_7475_726e, 48'h0073_7570_6572,
		48'h0000_7468_6973, 48'h0000_7472_7565, 48'h0000_0076_6172, 48'h0077_6869_6c65
	};
	localparam logic [2:0] KW_LEN [16] = '{
		3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
		3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
	};

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic [5:0] ident_kind(input logic [47:0] pfx, input logic [7:0] len,
			input logic over);
		logic [5:0] k;
		k = K_IDENT;
		if (!over && len <= 8'd6) begin
			for (int i = 0; i < 16; i++) begin
				if (KW_TEXT[i] == pfx && {5'd0, KW_LEN[i]} == len) k = 6'(i);
			end
		end
		return k;
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] k;
		unique case (c)
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			",": k = K_COMMA;
			".": k = K_DOT;
			";": k = K_SEMI;
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] op_kind(input logic [7:0] c, input logic with_eq);
		logic [5:0] b;
		priority if (c == "!") b = K_BANG;
		else if (c == "=") b = K_EQUAL;
		else if (c == ">") b = K_GREATER;
		else b = K_LESS;
		return with_eq ? b + 6'd1 : b;
	endfunction

	function automatic res_t mk(input logic [5:0] kind, input logic [2:0] err,
			input logic [POS_BITS-1:0] start, input logic [7:0] len,
			input logic [POS_BITS-1:0] line);
		res_t r;
		r.kind  = kind;
		r.err   = err;
		r.start = start;
		r.len   = len;
		r.line  = line;
		return r;
	endfunction

	function automatic grp_t add(input grp_t g, input res_t r);
		grp_t o;
		o = g;
		o.r[o.cnt] = r;
		o.cnt = o.cnt + 2'd1;
		return o;
	endfunction

endpackage
`default_nettype wire

>>> src/lts_in_if.sv
`default_nettype none
interface lts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	modport source(output valid, output char_byte, input ready);
	modport sink(input valid, input char_byte, output ready);
endinterface
`default_nettype wire

>>> src/lts_out_if.sv
`default_nettype none
interface lts_out_if;
	import lts_pkg::*;
	logic                valid;
	logic                ready;
	logic [5:0]          token_kind;
	logic [2:0]          error_code;
	logic [POS_BITS-1:0] token_start;
	logic [7:0]          token_length;
	logic [POS_BITS-1:0] line_number;
	logic                is_last;
	modport source(output valid, output token_kind, output error_code, output token_start,
		output token_length, output line_number, output is_last, input ready);
	modport sink(input valid, input token_kind, input error_code, input token_start,
		input token_length, input line_number, input is_last, output ready);
endinterface
`default_nettype wire

>>> src/lox_token_scanner_core.sv
`default_nettype none
// channel | dir | word
// in      | in  | char_byte: one source byte, 0 ends the text
// out     | out | token_kind, error_code, token_start, token_length, line_number, is_last
//
// One byte is taken per cycle while the queue has room; the scanner state updates
// in the same cycle. A byte yields 0 to 3 tokens; the output side delivers one token
// per cycle unless out.ready stalls it, so bytes that give several tokens are absorbed
// by a 4-entry group queue. Reset clears the scanner to line 1, position 0. Input
// stalls only when the queue is full; output stalls hold the registered token.
module lox_token_scanner_core (
	input  wire logic clk,
	input  wire logic arst_n,
	lts_in_if.sink    in,
	lts_out_if.source out
);
	import lts_pkg::*;

	logic q_ready, push, pop, nonempty;
	grp_t grp, head;

	lts_front u_front (
		.clk, .arst_n, .in, .q_ready, .push, .grp
	);

	lts_queue u_queue (
		.clk, .arst_n, .push, .wr_grp(grp), .ready(q_ready), .pop, .nonempty, .head
	);

	lts_back u_back (
		.clk, .arst_n, .q_valid(nonempty), .head, .pop, .out
	);

endmodule
`default_nettype wire

>>> src/lts_front.sv
`default_nettype none
module lts_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	lts_in_if.sink             in,
	input  wire logic          q_ready,
	output logic               push,
	output lts_pkg::grp_t      grp
);
	import lts_pkg::*;

	mode_t               md_q, md_n;
	logic [POS_BITS-1:0] pos_q, pos_n, line_q, line_n, st_q, st_n, prev;
	logic [7:0]          run_q, run_n, pend_q, pend_n, c;
	logic                ovr_q, ovr_n, halt_q, halt_n, do_idle, ended, tl;
	logic [47:0]         pfx_q, pfx_n;
	logic [5:0]          sk;
	grp_t                grp_n;

	assign in.ready = q_ready;
	assign grp      = grp_n;
	assign push     = in.valid && q_ready && grp_n.cnt != 2'd0;

	always_comb begin
		md_n = md_q; pos_n = pos_q; line_n = line_q; st_n = st_q; run_n = run_q;
		ovr_n = ovr_q; pfx_n = pfx_q; pend_n = pend_q; halt_n = halt_q;
		grp_n = '0; do_idle = 1'b0; ended = 1'b0; tl = 1'b0;
		c = in.char_byte;
		prev = pos_q - 1'b1;
		sk = single_kind(c);
		if (!halt_q) begin
			unique case (md_q)
				M_SLASH: begin
					if (c == "/") md_n = M_COMMENT;
					else begin
						grp_n = add(grp_n, mk(K_SLASH, E_NONE, prev, 8'd1, line_q));
						do_idle = 1'b1;
					end
				end
				M_COMMENT: begin
					if (c == "\n") begin
						if (line_q != LINE_MAX) line_n = line_q + 1'b1;
						md_n = M_IDLE;
					end else if (c == 8'd0) do_idle = 1'b1;
				end
				M_INT, M_FRAC: begin
					if (is_digit(c)) begin
						if (run_q == 8'hFF) ovr_n = 1'b1;
						else run_n = run_q + 8'd1;
					end else if (c == "." && md_q == M_INT) md_n = M_DOT;
					else begin
						md_n = M_IDLE;
						tl = ovr_q || run_q > 8'(MAX_NUMBER_LEN);
						halt_n = tl;
						grp_n = add(grp_n, mk(tl ? K_NONE : K_NUMBER, tl ? E_NUM_LONG : E_NONE,
							st_q, run_q, line_q));
						do_idle = 1'b1;
					end
				end
				M_DOT: begin
					if (is_digit(c)) begin
						// the dot and the digit both join the number
						if (run_n == 8'hFF) ovr_n = 1'b1;
						else run_n = run_n + 8'd1;
						if (run_n == 8'hFF) ovr_n = 1'b1;
						else run_n = run_n + 8'd1;
						md_n = M_FRAC;
					end else begin
						md_n = M_IDLE;
						tl = ovr_q || run_q > 8'(MAX_NUMBER_LEN);
						halt_n = tl;
						grp_n = add(grp_n, mk(tl ? K_NONE : K_NUMBER, tl ? E_NUM_LONG : E_NONE,
							st_q, run_q, line_q));
						if (!tl) grp_n = add(grp_n, mk(K_DOT, E_NONE, prev, 8'd1, line_q));
						do_idle = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c)) begin
						if (!ovr_q && run_q < 8'd6) pfx_n = {pfx_q[39:0], c};
						if (run_q == 8'hFF) ovr_n = 1'b1;
						else run_n = run_q + 8'd1;
					end else begin
						md_n = M_IDLE;
						tl = ovr_q || run_q > 8'(MAX_TEXT_LEN);
						halt_n = tl;
						grp_n = add(grp_n, mk(tl ? K_NONE : ident_kind(pfx_q, run_q, ovr_q),
							tl ? E_ID_LONG : E_NONE, st_q, run_q, line_q));
						do_idle = 1'b1;
					end
				end
				M_STRING: begin
					if (c == "\"") begin
						md_n = M_IDLE;
						tl = ovr_q || run_q > 8'(MAX_TEXT_LEN);
						halt_n = tl;
						grp_n = add(grp_n, mk(tl ? K_NONE : K_STRING, tl ? E_STR_LONG : E_NONE,
							st_q, run_q, line_q));
					end else if (c == 8'd0) begin
						halt_n = 1'b1;
						grp_n = add(grp_n, mk(K_NONE, E_UNTERM, st_q, run_q, line_q));
					end else begin
						if (c == "\n" && line_q != LINE_MAX) line_n = line_q + 1'b1;
						if (run_q == 8'hFF) ovr_n = 1'b1;
						else run_n = run_q + 8'd1;
					end
				end
				M_OP: begin
					if (c == "=") begin
						grp_n = add(grp_n, mk(op_kind(pend_q, 1'b1), E_NONE, prev, 8'd2, line_q));
						md_n = M_IDLE;
					end else begin
						grp_n = add(grp_n, mk(op_kind(pend_q, 1'b0), E_NONE, prev, 8'd1, line_q));
						do_idle = 1'b1;
					end
				end
				default: do_idle = 1'b1;
			endcase

			if (do_idle && !halt_n) begin
				md_n = M_IDLE;
				priority if (c == 8'd0) begin
					ended = 1'b1;
					grp_n = add(grp_n, mk(K_END, E_NONE, pos_q, 8'd0, line_n));
				end else if (c == "\n") begin
					if (line_n != LINE_MAX) line_n = line_n + 1'b1;
				end else if (c == " " || c == "\t" || c == "\r") begin
				end else if (c == "/") begin
					md_n = M_SLASH;
				end else if (is_digit(c)) begin
					st_n = pos_q; run_n = 8'd1; ovr_n = 1'b0; md_n = M_INT;
				end else if (is_alpha(c)) begin
					st_n = pos_q; run_n = 8'd1; ovr_n = 1'b0; md_n = M_IDENT;
					pfx_n = {40'd0, c};
				end else if (c == "\"") begin
					st_n = pos_q + 1'b1; run_n = 8'd0; ovr_n = 1'b0; md_n = M_STRING;
				end else if (c == "!" || c == "=" || c == "<" || c == ">") begin
					pend_n = c; md_n = M_OP;
				end else if (sk != K_NONE) begin
					grp_n = add(grp_n, mk(sk, E_NONE, pos_q, 8'd1, line_n));
				end else begin
					halt_n = 1'b1;
					grp_n = add(grp_n, mk(K_NONE, E_BAD_CHAR, pos_q, 8'd1, line_n));
				end
			end
		end

		// end of text returns everything to the reset state
		if (ended || (halt_n && c == 8'd0)) begin
			md_n = M_IDLE; pos_n = '0; line_n = POS_BITS'(1); st_n = '0; run_n = '0;
			ovr_n = 1'b0; pfx_n = '0; pend_n = '0; halt_n = 1'b0;
		end else pos_n = pos_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			md_q <= M_IDLE; pos_q <= '0; line_q <= POS_BITS'(1); st_q <= '0; run_q <= '0;
			ovr_q <= 1'b0; pfx_q <= '0; pend_q <= '0; halt_q <= 1'b0;
		end else if (in.valid && q_ready) begin
			md_q <= md_n; pos_q <= pos_n; line_q <= line_n; st_q <= st_n; run_q <= run_n;
			ovr_q <= ovr_n; pfx_q <= pfx_n; pend_q <= pend_n; halt_q <= halt_n;
		end
	end

endmodule
`default_nettype wire

>>> src/lts_queue.sv
`default_nettype none
module lts_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire lts_pkg::grp_t wr_grp,
	output logic               ready,
	input  wire logic          pop,
	output logic               nonempty,
	output lts_pkg::grp_t      head
);
	import lts_pkg::*;

	grp_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wp_q, rp_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign ready    = cnt_q != (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign nonempty = cnt_q != '0;
	assign head     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> src/lts_back.sv
`default_nettype none
module lts_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire lts_pkg::grp_t head,
	output logic               pop,
	lts_out_if.source          out
);
	import lts_pkg::*;

	logic       ovalid_q, last_q, free, last_now;
	logic [1:0] idx_q;
	res_t       res_q;

	assign free     = !ovalid_q || out.ready;
	assign last_now = idx_q == head.cnt - 2'd1;
	assign pop      = free && q_valid && last_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0; idx_q <= '0;
		end else if (free) begin
			ovalid_q <= q_valid;
			if (q_valid) idx_q <= last_now ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (free && q_valid) begin
			res_q  <= head.r[idx_q];
			last_q <= last_now;
		end
	end

	assign out.valid        = ovalid_q;
	assign out.token_kind   = res_q.kind;
	assign out.error_code   = res_q.err;
	assign out.token_start  = res_q.start;
	assign out.token_length = res_q.len;
	assign out.line_number  = res_q.line;
	assign out.is_last      = last_q;

endmodule
`default_nettype wire
